[hdl/least_loaded_dispatch_work_steal_macros.svh]
// Assertion macros used by the least_loaded_dispatch_work_steal module.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LEAST_LOADED_DISPATCH_WORK_STEAL_MACROS_SVH
`define LEAST_LOADED_DISPATCH_WORK_STEAL_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LLDWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// The condition must never be true outside reset.
`define LLDWS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[hdl/lldws_pkg.sv]
package lldws_pkg;

    localparam int CMD_W    = 2;
    localparam int WORKER_W = 4;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int QIDX_W   = 4;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_STEAL  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BALANCED  = 3'd3,
        ST_LAST_KEPT = 3'd4
    } t_status;

endpackage

[hdl/lldws_scan.sv]
module lldws_scan #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    i_occ [NUM_QUEUES],
    output logic [$clog2(NUM_QUEUES)-1:0]       o_least,
    output logic [$clog2(NUM_QUEUES)-1:0]       o_most
);

    localparam int LW = $clog2(NUM_QUEUES);
    localparam int P  = 1 << LW;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    logic [OW-1:0] w_mx_cnt [2*P];
    logic [LW-1:0] w_mx_idx [2*P];
    logic [OW:0]   w_mn_cnt [2*P];
    logic [LW-1:0] w_mn_idx [2*P];
    logic [LW-1:0] n_least;
    logic [LW-1:0] n_most;
    logic [LW-1:0] r_least;
    logic [LW-1:0] r_most;

    // Most loaded keeps the lower index on a tie, least loaded keeps the higher one.
    always_comb begin
        for (int i = 0; i < 2 * P; i++) begin
            w_mx_cnt[i] = '0;
            w_mx_idx[i] = '0;
            w_mn_cnt[i] = '0;
            w_mn_idx[i] = '0;
        end
        for (int i = 0; i < P; i++) begin
            w_mx_idx[P+i] = LW'(i);
            w_mn_idx[P+i] = LW'(i);
            if (i < NUM_QUEUES) begin
                w_mx_cnt[P+i] = i_occ[i];
                w_mn_cnt[P+i] = {1'b0, i_occ[i]};
            end else begin
                w_mx_cnt[P+i] = '0;
                w_mn_cnt[P+i] = {1'b1, {OW{1'b0}}};
            end
        end
        for (int n = P - 1; n >= 1; n--) begin
            if (w_mx_cnt[2*n+1] > w_mx_cnt[2*n]) begin
                w_mx_cnt[n] = w_mx_cnt[2*n+1];
                w_mx_idx[n] = w_mx_idx[2*n+1];
            end else begin
                w_mx_cnt[n] = w_mx_cnt[2*n];
                w_mx_idx[n] = w_mx_idx[2*n];
            end
            if (w_mn_cnt[2*n+1] <= w_mn_cnt[2*n]) begin
                w_mn_cnt[n] = w_mn_cnt[2*n+1];
                w_mn_idx[n] = w_mn_idx[2*n+1];
            end else begin
                w_mn_cnt[n] = w_mn_cnt[2*n];
                w_mn_idx[n] = w_mn_idx[2*n];
            end
        end
        n_least = w_mn_idx[1];
        n_most  = (w_mx_cnt[1] <= OW'(1)) ? w_mn_idx[1] : w_mx_idx[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least <= LW'(NUM_QUEUES - 1);
            r_most  <= LW'(NUM_QUEUES - 1);
        end else begin
            r_least <= n_least;
            r_most  <= n_most;
        end
    end

    assign o_least = r_least;
    assign o_most  = r_most;

endmodule

[hdl/lldws_ptr_mem.sv]
module lldws_ptr_mem #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(NUM_QUEUES)-1:0]     i_rd_addr,
    input  logic                              i_wr_en,
    input  logic [$clog2(NUM_QUEUES)-1:0]     i_wr_addr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    i_wr_head,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    i_wr_tail,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_rd_head,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_rd_tail
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [2*PW-1:0] r_mem [NUM_QUEUES];
    logic            r_vld [NUM_QUEUES];
    logic [2*PW-1:0] r_rd_data;
    logic            r_rd_vld;

    // An entry that was never written reads as both pointers at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_head, i_wr_tail};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_head = r_rd_vld ? r_rd_data[2*PW-1:PW] : '0;
    assign o_rd_tail = r_rd_vld ? r_rd_data[PW-1:0] : '0;

endmodule

[hdl/lldws_job_mem.sv]
module lldws_job_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/least_loaded_dispatch_work_steal.sv]
// Work-stealing dispatcher over NUM_QUEUES job-tag queues of QUEUE_DEPTH entries each.
// Every command item yields exactly one result item. When an item is accepted, the
// queue's head and tail pointers are read from the pointer memory. In S_EXEC the job
// memory is read or written and the occupancy count is updated. In S_DONE the job tag
// is collected and the output register is loaded once it is free. The next item is
// accepted only after the previous one has left S_DONE, so that the registered
// least/most loaded comparator tree sees the updated occupancy counts before the next
// command picks its queue. A result waiting in the output register does not block
// acceptance of the next item; only its completion waits for the output.
`include "least_loaded_dispatch_work_steal_macros.svh"

module least_loaded_dispatch_work_steal
    import lldws_pkg::*;
#(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: command[1:0], worker[5:2], job_tag[21:6], zero fill[23:22].
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // Fields from bit 0: status[2:0], queue_index[6:3], job_out[22:7], zero fill[23].
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [OW-1:0]        r_occ [NUM_QUEUES];
    t_cmd                 r_cmd;
    logic [QW-1:0]        r_q;
    logic [QIDX_W-1:0]    r_qidx;
    logic                 r_bal;
    logic                 r_pop_bad;
    logic [SW-1:0]        r_tag;
    t_status              r_status;
    logic                 r_take;
    logic                 r_out_vld;
    t_status              r_out_status;
    logic [QIDX_W-1:0]    r_out_qidx;
    logic [TAG_W-1:0]     r_out_job;

    t_cmd                 n_cmd;
    logic [WORKER_W-1:0]  w_worker;
    logic [TAG_W-1:0]     w_tag_in;
    logic [QW-1:0]        n_q;
    logic [QIDX_W-1:0]    n_qidx;
    logic [QW-1:0]        w_least;
    logic [QW-1:0]        w_most;
    logic [PW-1:0]        w_head;
    logic [PW-1:0]        w_tail;
    logic [PW-1:0]        n_head;
    logic [PW-1:0]        n_tail;
    logic [OW-1:0]        w_occ_q;
    logic                 w_store;
    logic                 w_take;
    t_status              n_status;
    logic                 w_exec;
    logic [SW-1:0]        w_rdata;
    logic                 w_out_free;

    assign n_cmd    = t_cmd'(s_axis_tdata[1:0]);
    assign w_worker = s_axis_tdata[5:2];
    assign w_tag_in = s_axis_tdata[21:6];
    assign w_exec   = (r_state == S_EXEC);

    always_comb begin
        case (n_cmd)
            CMD_SUBMIT: begin
                n_q    = w_least;
                n_qidx = QIDX_W'(w_least);
            end
            CMD_POP: begin
                n_q    = QW'(w_worker);
                n_qidx = w_worker;
            end
            CMD_STEAL: begin
                n_q    = w_most;
                n_qidx = QIDX_W'(w_most);
            end
            default: begin
                n_q    = '0;
                n_qidx = '0;
            end
        endcase
    end

    lldws_scan #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_occ   (r_occ),
        .o_least (w_least),
        .o_most  (w_most)
    );

    lldws_ptr_mem #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ptr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (n_q),
        .i_wr_en   (w_exec && (w_store || w_take)),
        .i_wr_addr (r_q),
        .i_wr_head (n_head),
        .i_wr_tail (n_tail),
        .o_rd_head (w_head),
        .o_rd_tail (w_tail)
    );

    lldws_job_mem #(
        .DEPTH  (NUM_QUEUES << PW),
        .DATA_W (SW)
    ) u_job_mem (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_store),
        .i_re    (w_exec && w_take),
        .i_addr  ({r_q, (w_store ? w_tail : w_head)}),
        .i_wdata (r_tag),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_occ_q  = r_occ[r_q];
        w_store  = (r_cmd == CMD_SUBMIT) && (w_occ_q != OW'(QUEUE_DEPTH));
        w_take   = ((r_cmd == CMD_POP) && !r_pop_bad && (w_occ_q != '0)) ||
                   ((r_cmd == CMD_STEAL) && !r_bal && (w_occ_q > OW'(1)));
        n_head   = w_head;
        n_tail   = w_tail;
        if (w_take) begin
            n_head = (w_head == PW'(QUEUE_DEPTH - 1)) ? '0 : w_head + PW'(1);
        end
        if (w_store) begin
            n_tail = (w_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : w_tail + PW'(1);
        end
        case (r_cmd)
            CMD_SUBMIT: begin
                n_status = w_store ? ST_OK : ST_FULL;
            end
            CMD_POP: begin
                n_status = w_take ? ST_OK : ST_EMPTY;
            end
            CMD_STEAL: begin
                if (r_bal) begin
                    n_status = ST_BALANCED;
                end else if (w_occ_q == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_occ_q == OW'(1)) begin
                    n_status = ST_LAST_KEPT;
                end else begin
                    n_status = ST_OK;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_occ[i] <= '0;
            end
        end else if (w_exec) begin
            if (w_store) begin
                r_occ[r_q] <= w_occ_q + OW'(1);
            end else if (w_take) begin
                r_occ[r_q] <= w_occ_q - OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && s_axis_tvalid) begin
            r_cmd     <= n_cmd;
            r_q       <= n_q;
            r_qidx    <= n_qidx;
            r_bal     <= (w_least == w_most);
            r_pop_bad <= ({{(32 - WORKER_W){1'b0}}, w_worker} >= 32'(NUM_QUEUES));
            r_tag     <= SW'(w_tag_in);
        end
        if (w_exec) begin
            r_status <= n_status;
            r_take   <= w_take;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_status <= r_status;
            r_out_qidx   <= r_qidx;
            r_out_job    <= r_take ? TAG_W'(w_rdata) : '0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_job, r_out_qidx, r_out_status};

    `LLDWS_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(r_state == S_DONE), "Result appeared outside completion")
    `LLDWS_NEVER(a_job_needs_ok, m_axis_tvalid && (r_out_status != ST_OK) && (r_out_job != '0), "Job tag returned with a failing status")
    `LLDWS_NEVER(a_occ_bound, w_exec && (w_occ_q > OW'(QUEUE_DEPTH)), "Queue count beyond its depth")
    `LLDWS_ASSERT(a_steal_keeps_one, (w_exec && (r_cmd == CMD_STEAL) && w_take) |-> (w_occ_q > OW'(1)), "Steal took the last job of a queue")

endmodule
